FILE: rtl/text_match_finder_assert.svh
// ----------------------------------------------------------------------------
// text_match_finder assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TEXT_MATCH_FINDER_ASSERT_SVH
`define TEXT_MATCH_FINDER_ASSERT_SVH

// implication into the next cycle, ignored while reset is held
`define TMF_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text_match_finder port check failed");

// implication into the next cycle, also checked across reset
`define TMF_CHECK_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("text_match_finder reset check failed");

`endif

FILE: rtl/tmf_pkg.sv
// ----------------------------------------------------------------------------
// tmf_pkg
// shared types, codes and byte helpers of the text match finder
// ----------------------------------------------------------------------------
package tmf_pkg;

  // counters and columns
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // configuration port
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam logic [2:0] REG_NEEDLE_LOW    = 3'd0;
  localparam logic [2:0] REG_NEEDLE_HIGH   = 3'd1;
  localparam logic [2:0] REG_NEEDLE_LENGTH = 3'd2;
  localparam logic [2:0] REG_CASE_SENS     = 3'd3;
  localparam logic [2:0] REG_MATCH_MODE    = 3'd4;
  localparam logic [2:0] REG_TAB_WIDTH     = 3'd5;

  // match modes
  localparam logic [1:0] MODE_CONTAINS    = 2'd0;
  localparam logic [1:0] MODE_WHOLE_WORD  = 2'd1;
  localparam logic [1:0] MODE_STARTS_WORD = 2'd2;
  localparam logic [1:0] MODE_ENDS_WORD   = 2'd3;

  localparam logic [6:0] TAB_RESET = 7'd4;

  // characters
  localparam logic [7:0] CHAR_TAB        = 8'h09;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;
  localparam logic [7:0] CASE_OFFSET     = 8'd32;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic       case_sens;
    logic [1:0] mode;
    logic [6:0] tab_width;   // never zero
  } cfg_t;

  // results caused by one item: slot a is a resolved pending match,
  // slot b a direct match or one closed by line end
  typedef struct packed {
    logic [CNT_W-1:0] line;
    logic             a_valid;
    logic [CNT_W-1:0] a_start;
    logic [CNT_W-1:0] a_end;
    logic             b_valid;
    logic [CNT_W-1:0] b_start;
    logic [CNT_W-1:0] b_end;
  } rec_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic is_boundary(input logic [7:0] c);
    logic word;
    word = (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
           (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
           (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) ||
           (c == CHAR_UNDERSCORE);
    return !word;
  endfunction

endpackage

FILE: rtl/tmf_if.sv
// ----------------------------------------------------------------------------
// tmf_if
// valid/ready channels of the text match finder
// ----------------------------------------------------------------------------
interface tmf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       has_byte;
  logic       line_last;
  logic       text_first;

  modport source (output valid, text_byte, has_byte, line_last, text_first,
                  input ready);
  modport sink   (input valid, text_byte, has_byte, line_last, text_first,
                  output ready);
endinterface

interface tmf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] line_number;
  logic [15:0] start_column;
  logic [15:0] end_column;
  logic        run_last;

  modport source (output valid, line_number, start_column, end_column, run_last,
                  input ready);
  modport sink   (input valid, line_number, start_column, end_column, run_last,
                  output ready);
endinterface

FILE: rtl/tmf_regs.sv
// ----------------------------------------------------------------------------
// tmf_regs
// configuration registers, read-back and the aligned needle pattern
// ----------------------------------------------------------------------------
module tmf_regs #(
  parameter int MAX_NEEDLE = 16,
  localparam int LEN_W = $clog2(MAX_NEEDLE + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tmf_pkg::ADDR_W-1:0]   paddr,
  input  logic [tmf_pkg::DATA_W-1:0]   pwdata,
  output logic [tmf_pkg::DATA_W-1:0]   prdata,
  output tmf_pkg::cfg_t                cfg,
  output logic [MAX_NEEDLE-1:0][7:0]   pat,
  output logic [LEN_W-1:0]             len,
  output logic [LEN_W-1:0]             len_m1,
  output logic                         tab_wr,
  output logic                         settle
);

  logic [63:0]  needle_low_r;
  logic [63:0]  needle_high_r;
  logic [4:0]   needle_length_r;
  logic         case_sens_r;
  logic [1:0]   match_mode_r;
  logic [6:0]   tab_width_r;
  logic         settle_r;
  logic [MAX_NEEDLE-1:0][7:0] pat_r;
  logic [MAX_NEEDLE-1:0][7:0] pat_nxt;
  logic [127:0] needle_all;
  logic [3:0]   pos;
  logic [7:0]   nb;
  logic         wr;
  logic [2:0]   idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_low_r    <= '0;
      needle_high_r   <= '0;
      needle_length_r <= '0;
      case_sens_r     <= 1'b0;
      match_mode_r    <= tmf_pkg::MODE_CONTAINS;
      tab_width_r     <= tmf_pkg::TAB_RESET;
      settle_r        <= 1'b0;
    end else begin
      settle_r <= wr;
      if (wr) begin
        case (idx)
          tmf_pkg::REG_NEEDLE_LOW:    needle_low_r    <= pwdata;
          tmf_pkg::REG_NEEDLE_HIGH:   needle_high_r   <= pwdata;
          tmf_pkg::REG_NEEDLE_LENGTH: needle_length_r <= pwdata[4:0];
          tmf_pkg::REG_CASE_SENS:     case_sens_r     <= pwdata[0];
          tmf_pkg::REG_MATCH_MODE:    match_mode_r    <= pwdata[1:0];
          tmf_pkg::REG_TAB_WIDTH:     tab_width_r     <= pwdata[6:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      tmf_pkg::REG_NEEDLE_LOW:    prdata = needle_low_r;
      tmf_pkg::REG_NEEDLE_HIGH:   prdata = needle_high_r;
      tmf_pkg::REG_NEEDLE_LENGTH: prdata = 64'(needle_length_r);
      tmf_pkg::REG_CASE_SENS:     prdata = 64'(case_sens_r);
      tmf_pkg::REG_MATCH_MODE:    prdata = 64'(match_mode_r);
      tmf_pkg::REG_TAB_WIDTH:     prdata = 64'(tab_width_r);
      default:                    prdata = '0;
    endcase
  end

  assign len = (needle_length_r > 5'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE)
                                                  : LEN_W'(needle_length_r);
  assign len_m1 = (len == '0) ? '0 : len - 1'b1;

  assign cfg.case_sens = case_sens_r;
  assign cfg.mode      = match_mode_r;
  assign cfg.tab_width = (tab_width_r == '0) ? 7'd1 : tab_width_r;

  // pattern reversed so that entry i lines up with the i-th newest text byte
  assign needle_all = {needle_high_r, needle_low_r};
  always_comb begin
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      pos = 4'(int'(len) - 1 - i);
      nb  = needle_all[pos*8 +: 8];
      pat_nxt[i] = case_sens_r ? nb : tmf_pkg::fold_byte(nb);
    end
  end

  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
  end

  assign pat    = pat_r;
  assign tab_wr = wr && (idx == tmf_pkg::REG_TAB_WIDTH);
  assign settle = settle_r;

endmodule

FILE: rtl/tmf_front.sv
// ----------------------------------------------------------------------------
// tmf_front
// takes text items, tracks line and columns, detects and classifies matches
// ----------------------------------------------------------------------------
module tmf_front #(
  parameter int MAX_NEEDLE = 16,
  localparam int LEN_W = $clog2(MAX_NEEDLE + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic [7:0]                 text_byte,
  input  logic                       has_byte,
  input  logic                       line_last,
  input  logic                       text_first,
  input  tmf_pkg::cfg_t              cfg,
  input  logic [MAX_NEEDLE-1:0][7:0] pat,
  input  logic [LEN_W-1:0]           len,
  input  logic [LEN_W-1:0]           len_m1,
  input  logic                       tab_wr,
  output logic                       busy,
  output logic                       push,
  output tmf_pkg::rec_t              rec
);

  localparam int CW    = tmf_pkg::CNT_W;
  localparam int HD    = MAX_NEEDLE + 1;
  localparam int BIL_W = $clog2(HD + 1);
  localparam int RC_W  = $clog2(CW + 1);
  localparam int BI_W  = $clog2(CW);
  localparam logic [BIL_W-1:0] BIL_SAT = BIL_W'(HD);

  logic [7:0]    hist_r [HD];
  logic [CW-1:0] colh_r [HD];
  logic [7:0]    hist_new [HD];
  logic [CW-1:0] colh_new [HD];

  logic [BIL_W-1:0] bil_r, bil0, bil1, bil_nxt;
  logic [CW-1:0]    col_r, col0, col1, col_nxt;
  logic [6:0]       cwt_r, cwt0, cwt1, cwt_nxt, cwt_inc;
  logic [CW-1:0]    line_r, line0, line_nxt;
  logic             pv_r, pv0, pv1, pv_nxt;
  logic [CW-1:0]    ps_r, pe_r, ps1, pe1;
  logic [CW:0]      col_sum;
  logic [MAX_NEEDLE-1:0] pos_ok;
  logic [7:0]       h;
  logic             all_eq, before_ok, hit, defer, direct;
  logic [CW-1:0]    mstart;

  // column remainder walk after a tab width change
  logic [RC_W-1:0]  rcnt_r;
  logic [6:0]       rem_r, rem_nxt;
  logic [BI_W-1:0]  bidx;
  logic [7:0]       rem_sh;

  // state as seen after a possible new-text restart
  assign bil0  = text_first ? '0 : bil_r;
  assign col0  = text_first ? '0 : col_r;
  assign cwt0  = text_first ? '0 : cwt_r;
  assign line0 = text_first ? '0 : line_r;
  assign pv0   = text_first ? 1'b0 : pv_r;

  always_comb begin
    hist_new[0] = text_byte;
    colh_new[0] = col0;
    for (int i = 1; i < HD; i++) begin
      hist_new[i] = hist_r[i-1];
      colh_new[i] = colh_r[i-1];
    end
  end

  // display column, tab stops kept by the offset within the current stop
  assign cwt_inc = cwt0 + 7'd1;
  always_comb begin
    if (text_byte == tmf_pkg::CHAR_TAB) begin
      col_sum = {1'b0, col0} + (CW+1)'(cfg.tab_width - cwt0);
      cwt1    = '0;
    end else begin
      col_sum = {1'b0, col0} + 1'b1;
      cwt1    = (cwt_inc >= cfg.tab_width) ? '0 : cwt_inc;
    end
    col1 = col_sum[CW] ? tmf_pkg::CNT_MAX : col_sum[CW-1:0];
  end

  assign bil1 = (bil0 == BIL_SAT) ? BIL_SAT : bil0 + 1'b1;

  always_comb begin
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      h = cfg.case_sens ? hist_new[i] : tmf_pkg::fold_byte(hist_new[i]);
      pos_ok[i] = (i >= int'(len)) || (h == pat[i]);
    end
  end

  assign all_eq    = &pos_ok;
  assign before_ok = !((cfg.mode == tmf_pkg::MODE_WHOLE_WORD ||
                        cfg.mode == tmf_pkg::MODE_STARTS_WORD) &&
                       (bil1 > BIL_W'(len)) &&
                       !tmf_pkg::is_boundary(hist_new[len]));
  assign hit    = has_byte && (len != '0) && (bil1 >= BIL_W'(len)) && all_eq && before_ok;
  assign defer  = (cfg.mode == tmf_pkg::MODE_WHOLE_WORD) ||
                  (cfg.mode == tmf_pkg::MODE_ENDS_WORD);
  assign direct = hit && !defer;
  assign mstart = colh_new[len_m1];

  assign pv1 = has_byte ? (hit && defer) : pv0;
  assign ps1 = (hit && defer) ? mstart : ps_r;
  assign pe1 = (hit && defer) ? col1 : pe_r;

  always_comb begin
    rec.line    = line0;
    rec.a_valid = has_byte && pv0 && tmf_pkg::is_boundary(text_byte);
    rec.a_start = ps_r;
    rec.a_end   = pe_r;
    rec.b_valid = direct || (line_last && pv1);
    rec.b_start = direct ? mstart : ps1;
    rec.b_end   = direct ? col1 : pe1;
  end

  assign push = in_fire && (rec.a_valid || rec.b_valid);

  always_comb begin
    if (line_last) begin
      bil_nxt  = '0;
      col_nxt  = '0;
      cwt_nxt  = '0;
      pv_nxt   = 1'b0;
      line_nxt = (line0 == tmf_pkg::CNT_MAX) ? line0 : line0 + 1'b1;
    end else begin
      bil_nxt  = has_byte ? bil1 : bil0;
      col_nxt  = has_byte ? col1 : col0;
      cwt_nxt  = has_byte ? cwt1 : cwt0;
      pv_nxt   = pv1;
      line_nxt = line0;
    end
  end

  // restoring remainder of the current column by the tab width, msb first
  assign bidx    = BI_W'(rcnt_r - 1'b1);
  assign rem_sh  = {rem_r, col_r[bidx]};
  assign rem_nxt = (rem_sh >= {1'b0, cfg.tab_width}) ? 7'(rem_sh - {1'b0, cfg.tab_width})
                                                      : rem_sh[6:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bil_r  <= '0;
      col_r  <= '0;
      cwt_r  <= '0;
      line_r <= '0;
      pv_r   <= 1'b0;
      rcnt_r <= '0;
    end else if (tab_wr) begin
      rcnt_r <= RC_W'(CW);
    end else if (rcnt_r != '0) begin
      rcnt_r <= rcnt_r - 1'b1;
      if (rcnt_r == RC_W'(1)) begin
        cwt_r <= rem_nxt;
      end
    end else if (in_fire) begin
      bil_r  <= bil_nxt;
      col_r  <= col_nxt;
      cwt_r  <= cwt_nxt;
      line_r <= line_nxt;
      pv_r   <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tab_wr) begin
      rem_r <= '0;
    end else if (rcnt_r != '0) begin
      rem_r <= rem_nxt;
    end
    if (in_fire) begin
      ps_r <= ps1;
      pe_r <= pe1;
      if (has_byte) begin
        for (int i = 0; i < HD; i++) begin
          hist_r[i] <= hist_new[i];
          colh_r[i] <= colh_new[i];
        end
      end
    end
  end

  assign busy = (rcnt_r != '0);

endmodule

FILE: rtl/tmf_queue.sv
// ----------------------------------------------------------------------------
// tmf_queue
// short record queue between the match front and the result back end
// ----------------------------------------------------------------------------
module tmf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tmf_pkg::rec_t wdata,
  output logic          full,
  input  logic          pop,
  output tmf_pkg::rec_t rdata,
  output logic          empty
);

  localparam int DEPTH = tmf_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  tmf_pkg::rec_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == LAST) ? '0 : rp_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  assign rdata = mem_r[rp_r];
  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);

endmodule

FILE: rtl/tmf_back.sv
// ----------------------------------------------------------------------------
// tmf_back
// splits queued records into result transactions on the output channel
// ----------------------------------------------------------------------------
module tmf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  tmf_pkg::rec_t rdata,
  input  logic          empty,
  output logic          pop,
  tmf_out_if.source     out_item
);

  tmf_pkg::rec_t rec_r;
  logic          hold_r;
  logic          sel_r;
  logic          use_a;
  logic          fire;
  logic          done;

  assign use_a = !sel_r && rec_r.a_valid;
  assign fire  = out_item.valid && out_item.ready;
  assign done  = fire && out_item.run_last;
  assign pop   = (!hold_r || done) && !empty;

  assign out_item.valid        = hold_r;
  assign out_item.line_number  = rec_r.line;
  assign out_item.start_column = use_a ? rec_r.a_start : rec_r.b_start;
  assign out_item.end_column   = use_a ? rec_r.a_end : rec_r.b_end;
  assign out_item.run_last     = use_a ? !rec_r.b_valid : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      sel_r  <= 1'b0;
    end else if (pop) begin
      hold_r <= 1'b1;
      sel_r  <= 1'b0;
    end else if (done) begin
      hold_r <= 1'b0;
    end else if (fire) begin
      sel_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r <= rdata;
    end
  end

endmodule

FILE: rtl/text_match_finder.sv
// ----------------------------------------------------------------------------
// text_match_finder
// streaming needle search over text lines with word rules and tab columns
// ----------------------------------------------------------------------------
//   channel   dir  transaction
//   in_item   in   one text byte or empty-line mark, line and text marks
//   out_item  out  one match: line, start and end display column, run_last
//   cfg_*     in   register write/read, 64-bit data, register i at 8*i
//
// one input transaction per cycle while in_item.ready is high; matching and
// column tracking are done in the front as each item is taken; results leave
// at one per cycle from the back while out_item.ready is high; an item with
// two results gives two output transactions; a four-record queue absorbs
// bursts so the front keeps taking bytes while the back stalls, until full;
// any register write drops in_item.ready for one cycle; a tab width write
// holds it low for the column remainder walk; reset is synchronous, active low
module text_match_finder #(
  parameter int MAX_NEEDLE = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tmf_in_if.sink                      in_item,
  tmf_out_if.source                   out_item,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tmf_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [tmf_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [tmf_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int LEN_W = $clog2(MAX_NEEDLE + 1);

  tmf_pkg::cfg_t              cfg;
  logic [MAX_NEEDLE-1:0][7:0] pat;
  logic [LEN_W-1:0]           len;
  logic [LEN_W-1:0]           len_m1;
  logic                       tab_wr;
  logic                       settle;
  logic                       busy;
  logic                       in_fire;
  logic                       push;
  logic                       full;
  logic                       pop;
  logic                       empty;
  tmf_pkg::rec_t              rec_w;
  tmf_pkg::rec_t              rec_r;

  assign cfg_pready    = 1'b1;
  assign in_item.ready = !busy && !settle && !full;
  assign in_fire       = in_item.valid && in_item.ready;

  tmf_regs #(.MAX_NEEDLE(MAX_NEEDLE)) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg),
    .pat     (pat),
    .len     (len),
    .len_m1  (len_m1),
    .tab_wr  (tab_wr),
    .settle  (settle)
  );

  tmf_front #(.MAX_NEEDLE(MAX_NEEDLE)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .text_byte  (in_item.text_byte),
    .has_byte   (in_item.has_byte),
    .line_last  (in_item.line_last),
    .text_first (in_item.text_first),
    .cfg        (cfg),
    .pat        (pat),
    .len        (len),
    .len_m1     (len_m1),
    .tab_wr     (tab_wr),
    .busy       (busy),
    .push       (push),
    .rec        (rec_w)
  );

  tmf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (rec_w),
    .full  (full),
    .pop   (pop),
    .rdata (rec_r),
    .empty (empty)
  );

  tmf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rdata    (rec_r),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

FILE: rtl/tmf_checker.sv
// ----------------------------------------------------------------------------
// tmf_checker
// port-level checks of the text match finder, bound to the top level
// ----------------------------------------------------------------------------
`include "text_match_finder_assert.svh"

module tmf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [15:0]                out_line_number,
  input logic [15:0]                out_start_column,
  input logic [15:0]                out_end_column,
  input logic                       out_run_last,
  input logic                       cfg_psel,
  input logic                       cfg_penable,
  input logic                       cfg_pwrite,
  input logic [tmf_pkg::ADDR_W-1:0] cfg_paddr
);

  logic cfg_wr;
  logic tab_wr;
  logic out_fire;

  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign tab_wr   = cfg_wr && (cfg_paddr[5:3] == tmf_pkg::REG_TAB_WIDTH);
  assign out_fire = out_valid && out_ready;

  // output register empties on reset
  `TMF_CHECK_NEXT_ALWAYS(a_reset_idle, !rst_n, !out_valid)

  // stalled result transaction holds
  `TMF_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_line_number) && $stable(out_start_column) && $stable(out_end_column) && $stable(out_run_last))

  // second result of an item follows straight on
  `TMF_CHECK_NEXT(a_pair_follows, out_fire && !out_run_last, out_valid)

  // no text taken while new settings propagate
  `TMF_CHECK_NEXT(a_cfg_settle, cfg_wr, !in_ready)

  // tab width change keeps input closed during the remainder walk
  `TMF_CHECK_NEXT(a_tab_walk, tab_wr, !in_ready ##1 !in_ready)

endmodule

bind text_match_finder tmf_checker u_tmf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_item.ready),
  .out_valid        (out_item.valid),
  .out_ready        (out_item.ready),
  .out_line_number  (out_item.line_number),
  .out_start_column (out_item.start_column),
  .out_end_column   (out_item.end_column),
  .out_run_last     (out_item.run_last),
  .cfg_psel         (cfg_psel),
  .cfg_penable      (cfg_penable),
  .cfg_pwrite       (cfg_pwrite),
  .cfg_paddr        (cfg_paddr)
);

FILE: tb/tb_text_match_finder.sv
// ----------------------------------------------------------------------------
// tb_text_match_finder
// self-checking bench for the streaming needle search: text items are queued
// by the stimulus process and driven over the input channel, an internal
// predictor tracks columns, lines and pending word matches, and every output
// transaction is compared with the oldest predicted match
// ----------------------------------------------------------------------------
module tb_text_match_finder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NEEDLE_MAX  = 16;
  localparam int unsigned CNT_LIMIT   = int'(tmf_pkg::CNT_MAX);
  localparam int unsigned DRAIN_WAIT  = 16;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_GOAL = 780;
  localparam int unsigned PHASE_ITEMS = 75;
  localparam int unsigned ERROR_SHOWN = 10;
  localparam logic [1:0] MODE_ORDER [4] =
    '{tmf_pkg::MODE_CONTAINS, tmf_pkg::MODE_WHOLE_WORD, tmf_pkg::MODE_STARTS_WORD,
      tmf_pkg::MODE_ENDS_WORD};

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       line_last;
    logic       text_first;
  } text_item_t;

  typedef struct packed {
    logic [15:0] line_number;
    logic [15:0] start_column;
    logic [15:0] end_column;
    logic        run_last;
  } match_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                          cfg_psel;
  logic                          cfg_penable;
  logic                          cfg_pwrite;
  logic [tmf_pkg::ADDR_W-1:0]    cfg_paddr;
  logic [tmf_pkg::DATA_W-1:0]    cfg_pwdata;
  logic [tmf_pkg::DATA_W-1:0]    cfg_prdata;
  logic                          cfg_pready;

  tmf_in_if  in_if ();
  tmf_out_if out_if ();

  text_match_finder u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_if),
    .out_item    (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // search settings as last written
  logic [63:0] cfg_needle_lo = '0;
  logic [63:0] cfg_needle_hi = '0;
  logic [4:0]  cfg_len       = '0;
  logic        cfg_case      = 1'b0;
  logic [1:0]  cfg_mode      = tmf_pkg::MODE_CONTAINS;
  logic [6:0]  cfg_tab       = tmf_pkg::TAB_RESET;

  // line tracking of the predictor, newest byte at index 0
  logic [7:0]  hist_byte [0:NEEDLE_MAX];
  logic [15:0] hist_col  [0:NEEDLE_MAX];
  int unsigned line_bytes = 0;
  int unsigned column     = 0;
  int unsigned line_no    = 0;
  bit          pend_valid = 1'b0;
  logic [15:0] pend_start = '0;
  logic [15:0] pend_end   = '0;

  text_item_t  text_q [$];
  match_t      awaited_matches [$];

  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned random_items   = 0;
  int unsigned matches_seen   = 0;
  int unsigned error_cnt      = 0;
  int unsigned setting_cnt    = 0;
  int unsigned gap_pct        = 0;
  int unsigned stall_pct      = 0;
  bit          in_accepted    = 1'b0;
  bit          hold_go        = 1'b0;
  bit          rx_hold        = 1'b0;

  function automatic int unsigned sat_add(input int unsigned a, input int unsigned b);
    return (a + b > CNT_LIMIT) ? CNT_LIMIT : a + b;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= tmf_pkg::CHAR_UPPER_A && c <= tmf_pkg::CHAR_UPPER_Z) ||
           (c >= tmf_pkg::CHAR_LOWER_A && c <= tmf_pkg::CHAR_LOWER_Z);
  endfunction

  function automatic bit is_word_char(input logic [7:0] c);
    return is_letter(c) || (c >= tmf_pkg::CHAR_DIGIT_0 && c <= tmf_pkg::CHAR_DIGIT_9) ||
           c == tmf_pkg::CHAR_UNDERSCORE;
  endfunction

  function automatic logic [7:0] lower_char(input logic [7:0] c);
    return (c >= tmf_pkg::CHAR_UPPER_A && c <= tmf_pkg::CHAR_UPPER_Z) ?
           c + tmf_pkg::CASE_OFFSET : c;
  endfunction

  function automatic void clear_line();
    int i;
    for (i = 0; i <= NEEDLE_MAX; i++) begin
      hist_byte[i] = '0;
      hist_col[i]  = '0;
    end
    line_bytes = 0;
    column     = 0;
  endfunction

  function automatic match_t make_match(input logic [15:0] s, input logic [15:0] e);
    return '{line_number: 16'(line_no), start_column: s, end_column: e, run_last: 1'b0};
  endfunction

  // advances the predictor by one accepted item and queues the matches it yields
  function automatic void find_matches(input text_item_t it);
    int unsigned  tw, len, k;
    int           i;
    logic [127:0] needle;
    logic [7:0]   h, nb;
    bit           hit;
    match_t       found [$];
    tw     = (cfg_tab == 0) ? 1 : cfg_tab;
    len    = (cfg_len > NEEDLE_MAX) ? NEEDLE_MAX : cfg_len;
    needle = {cfg_needle_hi, cfg_needle_lo};
    if (it.text_first) begin
      line_no = 0;
      clear_line();
      pend_valid = 1'b0;
    end
    if (it.has_byte) begin
      // a waiting word match is settled by the byte after it
      if (pend_valid) begin
        pend_valid = 1'b0;
        if (!is_word_char(it.text_byte))
          found.insert(found.size(), make_match(pend_start, pend_end));
      end
      for (i = NEEDLE_MAX; i > 0; i--) begin
        hist_byte[i] = hist_byte[i-1];
        hist_col[i]  = hist_col[i-1];
      end
      hist_byte[0] = it.text_byte;
      hist_col[0]  = 16'(column);
      if (it.text_byte == tmf_pkg::CHAR_TAB) column = sat_add(column, tw - column % tw);
      else column = sat_add(column, 1);
      line_bytes = sat_add(line_bytes, 1);
      if (len > 0 && line_bytes >= len) begin
        hit = 1'b1;
        for (k = 0; k < len; k++) begin
          h  = hist_byte[len-1-k];
          nb = needle[8*k +: 8];
          if (!cfg_case) begin
            h  = lower_char(h);
            nb = lower_char(nb);
          end
          if (h != nb) hit = 1'b0;
        end
        if (hit && (cfg_mode == tmf_pkg::MODE_WHOLE_WORD ||
                    cfg_mode == tmf_pkg::MODE_STARTS_WORD) &&
            line_bytes > len && is_word_char(hist_byte[len])) hit = 1'b0;
        if (hit) begin
          if (cfg_mode == tmf_pkg::MODE_WHOLE_WORD || cfg_mode == tmf_pkg::MODE_ENDS_WORD) begin
            pend_valid = 1'b1;
            pend_start = hist_col[len-1];
            pend_end   = 16'(column);
          end else begin
            found.insert(found.size(), make_match(hist_col[len-1], 16'(column)));
          end
        end
      end
    end
    if (it.line_last) begin
      if (pend_valid) begin
        pend_valid = 1'b0;
        found.insert(found.size(), make_match(pend_start, pend_end));
      end
      line_no = sat_add(line_no, 1);
      clear_line();
    end
    foreach (found[j]) begin
      found[j].run_last = (j == found.size() - 1);
      awaited_matches.insert(awaited_matches.size(), found[j]);
    end
  endfunction

  function automatic void note_error(input string msg);
    error_cnt++;
    if (error_cnt <= ERROR_SHOWN) $display("%s", msg);
  endfunction

  // input driver: next item offered once the current one has gone
  always @(negedge clk) begin : drive_text
    text_item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_accepted) begin
      if (text_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        nxt = text_q.pop_front();
        in_if.valid      <= 1'b1;
        in_if.text_byte  <= nxt.text_byte;
        in_if.has_byte   <= nxt.has_byte;
        in_if.line_last  <= nxt.line_last;
        in_if.text_first <= nxt.text_first;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (!rst_n) out_if.ready <= 1'b0;
    else out_if.ready <= !rx_hold && ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin : rx_hold_off
    wait (hold_go);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin : monitor
    text_item_t seen;
    match_t     got, want;
    if (!rst_n) begin
      in_accepted <= 1'b0;
    end else begin
      in_accepted <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        seen = '{in_if.text_byte, in_if.has_byte, in_if.line_last, in_if.text_first};
        find_matches(seen);
        items_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.line_number, out_if.start_column, out_if.end_column, out_if.run_last};
        matches_seen++;
        if (awaited_matches.size() == 0) begin
          note_error($sformatf("unexpected match: line %0d cols %0d..%0d last %0b",
                               got.line_number, got.start_column, got.end_column,
                               got.run_last));
        end else begin
          want = awaited_matches.pop_front();
          if (got !== want)
            note_error($sformatf({"match mismatch: expected line %0d cols %0d..%0d last %0b,",
                                  " got line %0d cols %0d..%0d last %0b"},
                                 want.line_number, want.start_column, want.end_column,
                                 want.run_last, got.line_number, got.start_column,
                                 got.end_column, got.run_last));
        end
      end
    end
  end

  task automatic queue_item(input logic [7:0] b, input bit has, input bit last,
                            input bit first);
    text_q.insert(text_q.size(),
                  text_item_t'{text_byte: b, has_byte: has, line_last: last, text_first: first});
    items_queued++;
  endtask

  // every queued item taken, every match back, then let the back end empty
  task automatic settle();
    while (items_accepted != items_queued || awaited_matches.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      tmf_pkg::REG_NEEDLE_LOW:    cfg_needle_lo = data;
      tmf_pkg::REG_NEEDLE_HIGH:   cfg_needle_hi = data;
      tmf_pkg::REG_NEEDLE_LENGTH: cfg_len       = data[4:0];
      tmf_pkg::REG_CASE_SENS:     cfg_case      = data[0];
      tmf_pkg::REG_MATCH_MODE:    cfg_mode      = data[1:0];
      tmf_pkg::REG_TAB_WIDTH:     cfg_tab       = data[6:0];
      default: ;
    endcase
  endtask

  task automatic set_search(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] len, input bit cs, input logic [1:0] mode,
                            input logic [6:0] tab);
    settle();
    cfg_write(tmf_pkg::REG_NEEDLE_LOW, lo);
    cfg_write(tmf_pkg::REG_NEEDLE_HIGH, hi);
    cfg_write(tmf_pkg::REG_NEEDLE_LENGTH, 64'(len));
    cfg_write(tmf_pkg::REG_CASE_SENS, 64'(cs));
    cfg_write(tmf_pkg::REG_MATCH_MODE, 64'(mode));
    cfg_write(tmf_pkg::REG_TAB_WIDTH, 64'(tab));
    setting_cnt++;
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1: return "a";
      2:    return "b";
      3:    return "A";
      4:    return "B";
      5:    return tmf_pkg::CHAR_UNDERSCORE;
      6:    return " ";
      7:    return tmf_pkg::CHAR_TAB;
      8:    return 8'($urandom_range(0, 255));
      default: return "9";
    endcase
  endfunction

  // one line built from needle copies, near misses, word bytes and separators
  task automatic queue_random_line();
    logic [7:0]   line_q [$];
    logic [7:0]   c;
    logic [127:0] needle;
    int unsigned  len, cut, k;
    bit           first, ended;
    needle = {cfg_needle_hi, cfg_needle_lo};
    len    = (cfg_len > NEEDLE_MAX) ? NEEDLE_MAX : cfg_len;
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 4))
        0, 1: begin
          cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len) : len;
          for (k = 0; k < cut; k++) begin
            c = needle[8*k +: 8];
            if (is_letter(c) && $urandom_range(0, 1)) c = c ^ tmf_pkg::CASE_OFFSET;
            line_q.insert(line_q.size(), c);
          end
        end
        2: repeat ($urandom_range(1, 3)) line_q.insert(line_q.size(), pick_char());
        3: line_q.insert(line_q.size(), 8'($urandom_range(0, 255)));
        default: line_q.insert(line_q.size(), " ");
      endcase
    end
    first = ($urandom_range(0, 11) == 0);
    ended = ($urandom_range(0, 9) != 0);
    // bare marks: no byte and no line end
    if ($urandom_range(0, 15) == 0)
      queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
    if (line_q.size() == 0) begin
      queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, first);
      random_items++;
    end else begin
      foreach (line_q[j]) begin
        queue_item(line_q[j], 1'b1, ended && j == line_q.size() - 1, first && j == 0);
        random_items++;
      end
    end
  endtask

  task automatic set_idling(input int unsigned sel);
    case (sel % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 48; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 48; end
      default: begin gap_pct = 29; stall_pct = 29; end
    endcase
  endtask

  initial begin : stimulus
    int unsigned  p, k, len, phase_start;
    logic [127:0] bits;
    logic [6:0]   tab;
    in_if.valid      = 1'b0;
    in_if.text_byte  = '0;
    in_if.has_byte   = 1'b0;
    in_if.line_last  = 1'b0;
    in_if.text_first = 1'b0;
    out_if.ready     = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    clear_line();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sixteen-byte needle of a tab and zero bytes, oversized length, zero tab width
    set_search({56'h0, tmf_pkg::CHAR_TAB}, '0, 5'd31, 1'b1, tmf_pkg::MODE_CONTAINS, 7'd0);
    queue_item(tmf_pkg::CHAR_TAB, 1'b1, 1'b0, 1'b1);
    repeat (14) queue_item(8'h00, 1'b1, 1'b0, 1'b0);
    queue_item(8'h00, 1'b1, 1'b1, 1'b0);

    // folded compare with overlaps, a bare mark, then a tab width change mid-line
    set_search({48'h0, 8'h41, 8'h61}, '1, 5'd2, 1'b0, tmf_pkg::MODE_CONTAINS, 7'd64);
    queue_item("a", 1'b1, 1'b0, 1'b0);
    queue_item("A", 1'b1, 1'b0, 1'b0);
    queue_item("a", 1'b1, 1'b0, 1'b0);
    queue_item(8'hFF, 1'b0, 1'b0, 1'b0);
    settle();
    cfg_write(tmf_pkg::REG_TAB_WIDTH, 64'd3);
    queue_item(tmf_pkg::CHAR_TAB, 1'b1, 1'b0, 1'b0);
    queue_item("a", 1'b1, 1'b0, 1'b0);
    queue_item("A", 1'b1, 1'b1, 1'b0);

    // ends-word: one item settles the old match and closes the new one at line end
    set_search({56'h0, 8'h2E}, '0, 5'd1, 1'b1, tmf_pkg::MODE_ENDS_WORD, 7'd4);
    queue_item(".", 1'b1, 1'b0, 1'b0);
    queue_item(".", 1'b1, 1'b1, 1'b0);

    // back end held off while the sender keeps pushing single-byte hits
    set_search({56'h0, 8'h61}, '0, 5'd1, 1'b1, tmf_pkg::MODE_CONTAINS, 7'd4);
    hold_go = 1'b1;
    for (k = 0; k < 80; k++) queue_item("a", 1'b1, (k % 20) == 19, 1'b0);

    // random settings and text
    for (p = 0; random_items < RANDOM_GOAL; p++) begin
      for (k = 0; k < NEEDLE_MAX; k++) bits[8*k +: 8] = pick_char();
      case ($urandom_range(0, 19))
        0:       len = 0;
        1:       len = $urandom_range(17, 31);
        2, 3, 4: len = $urandom_range(5, 16);
        default: len = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 5))
        0:       tab = 7'd0;
        1:       tab = 7'd1;
        2:       tab = 7'd127;
        3:       tab = 7'd64;
        default: tab = 7'($urandom_range(2, 8));
      endcase
      set_search(bits[63:0], bits[127:64], 5'(len), 1'($urandom_range(0, 1)),
                 MODE_ORDER[(p + p / 4) % 4], tab);
      set_idling(p);
      phase_start = random_items;
      while (random_items - phase_start < PHASE_ITEMS) queue_random_line();
    end

    settle();
    $display("run covered %0d text items and %0d matches over %0d search settings, %0d errors",
             items_accepted, matches_seen, setting_cnt, error_cnt);
    $display("includes a %0d-cycle output hold-off, a mid-line tab width change and paired results",
             HOLD_CYCLES);
    if (error_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
